[rtl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/dftl_pkg.sv]
package dftl_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int LINE_OUT_W    = 16;
    localparam int MAX_RES       = 3;

    localparam logic [3:0] K_TEXT    = 4'd0;
    localparam logic [3:0] K_ERR     = 4'd1;
    localparam logic [3:0] K_COMMA   = 4'd2;
    localparam logic [3:0] K_LBRACE  = 4'd3;
    localparam logic [3:0] K_RBRACE  = 4'd4;
    localparam logic [3:0] K_LBRACK  = 4'd5;
    localparam logic [3:0] K_RBRACK  = 4'd6;
    localparam logic [3:0] K_LPAREN  = 4'd7;
    localparam logic [3:0] K_RPAREN  = 4'd8;
    localparam logic [3:0] K_IDENT   = 4'd9;
    localparam logic [3:0] K_NUMBER  = 4'd10;
    localparam logic [3:0] K_STRING  = 4'd11;
    localparam logic [3:0] K_KW_BASE = 4'd12;

    localparam logic [1:0] KW_NONE = 2'd3;

    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_AT     = 8'h40;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_USCORE = 8'h5F;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_LO_A   = 8'h61;
    localparam logic [7:0] C_LO_D   = 8'h64;
    localparam logic [7:0] C_LO_E   = 8'h65;
    localparam logic [7:0] C_LO_F   = 8'h66;
    localparam logic [7:0] C_LO_I   = 8'h69;
    localparam logic [7:0] C_LO_L   = 8'h6C;
    localparam logic [7:0] C_LO_N   = 8'h6E;
    localparam logic [7:0] C_LO_O   = 8'h6F;
    localparam logic [7:0] C_LO_R   = 8'h72;
    localparam logic [7:0] C_LO_T   = 8'h74;
    localparam logic [7:0] C_LO_U   = 8'h75;
    localparam logic [7:0] C_LO_B   = 8'h62;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
    } t_res;

    typedef struct packed {
        logic [1:0]                  cnt;
        t_res [MAX_RES-1:0]          res;
        logic [LINE_OUT_W-1:0]       line;
    } t_bundle;

    typedef struct packed {
        logic err_stuck;
    } t_lex_stat;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == C_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        return l >= C_LO_A && l <= 8'h7A;
    endfunction

    function automatic logic num_char(input logic [7:0] c);
        return c == C_PLUS || c == C_MINUS || c == C_DOT || is_digit(c) ||
               c == C_LO_E || c == 8'h45;
    endfunction

    function automatic logic ident_char(input logic [7:0] c);
        return c == C_USCORE || c == C_MINUS || is_digit(c) || is_alpha(c);
    endfunction

    // rest of the keyword after its first letter: ttribute / ata / elation
    function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (sel)
            2'd0: begin
                case (pos)
                    3'd0: r = C_LO_T;
                    3'd1: r = C_LO_T;
                    3'd2: r = C_LO_R;
                    3'd3: r = C_LO_I;
                    3'd4: r = C_LO_B;
                    3'd5: r = C_LO_U;
                    3'd6: r = C_LO_T;
                    default: r = C_LO_E;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: r = C_LO_A;
                    3'd1: r = C_LO_T;
                    3'd2: r = C_LO_A;
                    default: r = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: r = C_LO_E;
                    3'd1: r = C_LO_L;
                    3'd2: r = C_LO_A;
                    3'd3: r = C_LO_T;
                    3'd4: r = C_LO_I;
                    3'd5: r = C_LO_O;
                    3'd6: r = C_LO_N;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kw_len(input logic [1:0] sel);
        logic [3:0] r;
        case (sel)
            2'd0: r = 4'd8;
            2'd1: r = 4'd3;
            2'd2: r = 4'd7;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/dftl_chan_if.sv]
interface dftl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_stream;

    modport source (output valid, output char_byte, output end_of_stream, input ready);
    modport sink   (input valid, input char_byte, input end_of_stream, output ready);
endinterface

interface dftl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  item_kind;
    logic [7:0]  text_char;
    logic [15:0] line_number;
    logic        last_of_input;

    modport source (output valid, output item_kind, output text_char, output line_number,
                    output last_of_input, input ready);
    modport sink   (input valid, input item_kind, input text_char, input line_number,
                    input last_of_input, output ready);
endinterface

[rtl/dftl_lex.sv]
module dftl_lex #(
    parameter int LINE_BITS = dftl_pkg::LINE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_eos,
    output dftl_pkg::t_bundle   o_bundle,
    output dftl_pkg::t_lex_stat o_stat
);
    import dftl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_STRING, M_KW_FIRST, M_KW_MATCH, M_KW_SPACE,
        M_I, M_IN, M_SIGN, M_SIGN_I, M_SIGN_IN, M_NUMBER, M_IDENT
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [3:0]           r_kw_pos, n_kw_pos;
    logic [1:0]           r_kw_sel, n_kw_sel;
    logic                 r_quote, n_quote;
    logic [7:0]           r_held, n_held;
    logic                 r_err, n_err;
    logic [LINE_BITS-1:0] r_line, n_line;

    logic [7:0]          l;
    logic [1:0]          cnt;
    t_res [MAX_RES-1:0]  res;
    logic                do_start;
    logic                do_fail;
    logic                bump;

    always_comb begin
        n_mode   = r_mode;
        n_kw_pos = r_kw_pos;
        n_kw_sel = r_kw_sel;
        n_quote  = r_quote;
        n_held   = r_held;
        n_err    = r_err;
        n_line   = r_line;
        cnt      = 2'd0;
        res      = '0;
        do_start = 1'b0;
        do_fail  = 1'b0;
        bump     = 1'b0;
        l        = to_lower(i_byte);

        if (r_err) begin
            res[cnt].kind = K_ERR;
            cnt = cnt + 2'd1;
        end else if (i_eos) begin
            case (r_mode)
                M_NUMBER, M_SIGN: begin
                    res[cnt].kind = K_NUMBER;
                    cnt = cnt + 2'd1;
                end
                M_IDENT, M_I: begin
                    res[cnt].kind = K_IDENT;
                    cnt = cnt + 2'd1;
                end
                M_IN: begin
                    res[cnt].ch = r_held;
                    cnt = cnt + 2'd1;
                    res[cnt].kind = K_IDENT;
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
            do_fail = 1'b1;
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (i_byte == C_LF) begin
                        bump   = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (i_byte == (r_quote ? C_SQUOTE : C_DQUOTE)) begin
                        res[cnt].kind = K_STRING;
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                    end
                end
                M_KW_FIRST: begin
                    n_kw_pos = 4'd0;
                    n_mode   = M_KW_MATCH;
                    if (l == C_LO_A) n_kw_sel = 2'd0;
                    else if (l == C_LO_D) n_kw_sel = 2'd1;
                    else if (l == C_LO_R) n_kw_sel = 2'd2;
                    else do_fail = 1'b1;
                end
                M_KW_MATCH: begin
                    if (r_kw_sel == KW_NONE || r_kw_pos > 4'd7 ||
                        l != kw_char(r_kw_sel, r_kw_pos[2:0])) begin
                        do_fail = 1'b1;
                    end else begin
                        n_kw_pos = r_kw_pos + 4'd1;
                        if (n_kw_pos == kw_len(r_kw_sel)) n_mode = M_KW_SPACE;
                    end
                end
                M_KW_SPACE: begin
                    if (is_space(i_byte) && r_kw_sel != KW_NONE) begin
                        res[cnt].kind = K_KW_BASE + {2'b00, r_kw_sel};
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                M_I: begin
                    if (l == C_LO_N) begin
                        n_held = i_byte;
                        n_mode = M_IN;
                    end else if (ident_char(i_byte)) begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                        n_mode = M_IDENT;
                    end else begin
                        res[cnt].kind = K_IDENT;
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_IN: begin
                    if (l == C_LO_F) begin
                        res[cnt].ch = C_LO_N;
                        cnt = cnt + 2'd1;
                        res[cnt].ch = C_LO_F;
                        cnt = cnt + 2'd1;
                        res[cnt].kind = K_NUMBER;
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt].ch = r_held;
                        cnt = cnt + 2'd1;
                        if (ident_char(i_byte)) begin
                            res[cnt].ch = i_byte;
                            cnt = cnt + 2'd1;
                            n_mode = M_IDENT;
                        end else begin
                            res[cnt].kind = K_IDENT;
                            cnt = cnt + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                end
                M_SIGN: begin
                    if (l == C_LO_I) begin
                        res[cnt].ch = C_LO_I;
                        cnt = cnt + 2'd1;
                        n_mode = M_SIGN_I;
                    end else if (num_char(i_byte)) begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                        n_mode = M_NUMBER;
                    end else begin
                        res[cnt].kind = K_NUMBER;
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_SIGN_I: begin
                    if (l == C_LO_N) begin
                        res[cnt].ch = C_LO_N;
                        cnt = cnt + 2'd1;
                        n_mode = M_SIGN_IN;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                M_SIGN_IN: begin
                    if (l == C_LO_F) begin
                        res[cnt].ch = C_LO_F;
                        cnt = cnt + 2'd1;
                        res[cnt].kind = K_NUMBER;
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (num_char(i_byte)) begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                    end else begin
                        res[cnt].kind = K_NUMBER;
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (ident_char(i_byte)) begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                    end else begin
                        res[cnt].kind = K_IDENT;
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        // token start on the current byte
        if (do_start) begin
            n_mode = M_IDLE;
            if (is_space(i_byte)) begin
                if (i_byte == C_LF) bump = 1'b1;
            end else begin
                case (i_byte)
                    C_PCT:    n_mode = M_COMMENT;
                    C_COMMA:  begin res[cnt].kind = K_COMMA;  cnt = cnt + 2'd1; end
                    C_LBRACE: begin res[cnt].kind = K_LBRACE; cnt = cnt + 2'd1; end
                    C_RBRACE: begin res[cnt].kind = K_RBRACE; cnt = cnt + 2'd1; end
                    C_LBRACK: begin res[cnt].kind = K_LBRACK; cnt = cnt + 2'd1; end
                    C_RBRACK: begin res[cnt].kind = K_RBRACK; cnt = cnt + 2'd1; end
                    C_LPAREN: begin res[cnt].kind = K_LPAREN; cnt = cnt + 2'd1; end
                    C_RPAREN: begin res[cnt].kind = K_RPAREN; cnt = cnt + 2'd1; end
                    C_DQUOTE: begin n_quote = 1'b0; n_mode = M_STRING; end
                    C_SQUOTE: begin n_quote = 1'b1; n_mode = M_STRING; end
                    C_AT:     n_mode = M_KW_FIRST;
                    C_LO_I: begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                        n_mode = M_I;
                    end
                    C_PLUS, C_MINUS: begin
                        res[cnt].ch = i_byte;
                        cnt = cnt + 2'd1;
                        n_mode = M_SIGN;
                    end
                    default: begin
                        if (i_byte == C_DOT || is_digit(i_byte)) begin
                            res[cnt].ch = i_byte;
                            cnt = cnt + 2'd1;
                            n_mode = M_NUMBER;
                        end else if (i_byte == C_USCORE || is_alpha(i_byte)) begin
                            res[cnt].ch = i_byte;
                            cnt = cnt + 2'd1;
                            n_mode = M_IDENT;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (do_fail) begin
            res[cnt].kind = K_ERR;
            cnt = cnt + 2'd1;
            n_err  = 1'b1;
            n_mode = M_IDLE;
        end

        if (bump && r_line != {LINE_BITS{1'b1}}) n_line = r_line + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_kw_pos <= 4'd0;
            r_kw_sel <= 2'd0;
            r_quote  <= 1'b0;
            r_held   <= 8'd0;
            r_err    <= 1'b0;
            r_line   <= {{(LINE_BITS-1){1'b0}}, 1'b1};
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_kw_pos <= n_kw_pos;
            r_kw_sel <= n_kw_sel;
            r_quote  <= n_quote;
            r_held   <= n_held;
            r_err    <= n_err;
            r_line   <= n_line;
        end
    end

    // all results of one byte carry the line count from before that byte
    assign o_bundle.cnt  = cnt;
    assign o_bundle.res  = res;
    assign o_bundle.line = LINE_OUT_W'(r_line);
    assign o_stat.err_stuck = r_err;

endmodule

[rtl/dftl_obuf.sv]
module dftl_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dftl_pkg::t_bundle i_bundle,
    output logic              o_free,
    dftl_out_if.source        o_res
);
    import dftl_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_bundle    r_bundle;
    logic       last;

    assign last   = r_idx == r_bundle.cnt - 2'd1;
    assign o_free = !r_valid || (o_res.ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && o_res.ready) begin
            if (last) r_valid <= 1'b0;
            else r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_bundle <= i_bundle;
    end

    assign o_res.valid         = r_valid;
    assign o_res.item_kind     = r_bundle.res[r_idx].kind;
    assign o_res.text_char     = r_bundle.res[r_idx].ch;
    assign o_res.line_number   = r_bundle.line;
    assign o_res.last_of_input = last;

endmodule

[rtl/data_file_token_lexer_core.sv]
// Path: an accepted request passes the input register, then the result register,
//   where its first result shows; it waits in the input register while free is low.
// Throughput: one request per cycle while each has at most one result and o_res is
//   ready; a request with n results holds the result register until all are taken.
// Reset: synchronous, active low; lexer idle, line count 1, error cleared.
module data_file_token_lexer_core #(
    parameter int LINE_BITS = dftl_pkg::LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dftl_in_if.sink    i_req,
    dftl_out_if.source o_res
);
    import dftl_pkg::*;
    `include "assert_macros.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       consume;
    logic       load;
    logic       free;
    t_bundle    bundle;
    t_lex_stat  lex_stat;

    assign consume     = r_in_valid && free;
    assign load        = consume && bundle.cnt != 2'd0;
    assign i_req.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.char_byte;
            r_in_eos  <= i_req.end_of_stream;
        end
    end

    dftl_lex #(
        .LINE_BITS (LINE_BITS)
    ) u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (consume),
        .i_byte   (r_in_byte),
        .i_eos    (r_in_eos),
        .o_bundle (bundle),
        .o_stat   (lex_stat)
    );

    dftl_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (free),
        .o_res    (o_res)
    );

    `ASSERT_IMPL(a_err_single, i_clk, i_rst_n, consume && lex_stat.err_stuck, bundle.cnt == 2'd1 && bundle.res[0].kind == K_ERR)
    `ASSERT_NEXT(a_req_held, i_clk, i_rst_n, i_req.valid && i_req.ready, r_in_valid)
    `ASSERT_IMPL(a_char_zero, i_clk, i_rst_n, o_res.valid && o_res.item_kind != K_TEXT, o_res.text_char == 8'd0)

endmodule

[sim/data_file_token_lexer_core_checker.sv]
module data_file_token_lexer_core_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dftl_in_if   i_req,
    dftl_out_if  i_res,
    output int   o_fail_cnt,
    output int   o_pending
);
    import dftl_pkg::*;

    typedef enum logic [3:0] {
        LX_IDLE, LX_COMMENT, LX_STRING, LX_AT, LX_KW, LX_KW_END, LX_I, LX_IN,
        LX_SIGN, LX_SIGN_I, LX_SIGN_IN, LX_NUM, LX_IDENT
    } lex_mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  ch;
        logic [15:0] line;
        logic        last;
    } tok_item_t;

    lex_mode_t   mode;
    int          kw_pos;
    logic [1:0]  kw_sel;
    logic        single_q;
    logic [7:0]  held;
    logic        stuck;
    logic [15:0] lines;

    tok_item_t step_items[$];
    tok_item_t due_tokens[$];
    tok_item_t want;
    int        fails = 0;
    int        pend = 0;

    assign o_fail_cnt = fails;
    assign o_pending  = pend;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic ws(input logic [7:0] c);
        return c == C_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic alpha(input logic [7:0] c);
        return fold(c) >= 8'h61 && fold(c) <= 8'h7A;
    endfunction

    function automatic logic numc(input logic [7:0] c);
        return c == C_PLUS || c == C_MINUS || c == C_DOT || dig(c) || fold(c) == C_LO_E;
    endfunction

    function automatic logic idc(input logic [7:0] c);
        return c == C_USCORE || c == C_MINUS || dig(c) || alpha(c);
    endfunction

    function automatic string kw_rest(input logic [1:0] sel);
        case (sel)
            2'd0: return "ttribute";
            2'd1: return "ata";
            2'd2: return "elation";
            default: return "";
        endcase
    endfunction

    function automatic void put(input logic [3:0] k, input logic [7:0] c);
        tok_item_t it;
        it = '{kind: k, ch: c, line: lines, last: 1'b0};
        if (step_items.size() < MAX_RES)
            step_items.insert(step_items.size(), it);
    endfunction

    function automatic void bump();
        if (lines != 16'hFFFF)
            lines++;
    endfunction

    function automatic void raise_err();
        put(K_ERR, 8'h00);
        stuck = 1'b1;
        mode = LX_IDLE;
    endfunction

    function automatic void begin_tok(input logic [7:0] c);
        mode = LX_IDLE;
        if (ws(c)) begin
            if (c == C_LF)
                bump();
        end else begin
            case (c)
                C_PCT:    mode = LX_COMMENT;
                C_COMMA:  put(K_COMMA, 8'h00);
                C_LBRACE: put(K_LBRACE, 8'h00);
                C_RBRACE: put(K_RBRACE, 8'h00);
                C_LBRACK: put(K_LBRACK, 8'h00);
                C_RBRACK: put(K_RBRACK, 8'h00);
                C_LPAREN: put(K_LPAREN, 8'h00);
                C_RPAREN: put(K_RPAREN, 8'h00);
                C_DQUOTE: begin
                    single_q = 1'b0;
                    mode = LX_STRING;
                end
                C_SQUOTE: begin
                    single_q = 1'b1;
                    mode = LX_STRING;
                end
                C_AT:     mode = LX_AT;
                C_LO_I: begin
                    put(K_TEXT, c);
                    mode = LX_I;
                end
                C_PLUS, C_MINUS: begin
                    put(K_TEXT, c);
                    mode = LX_SIGN;
                end
                default: begin
                    if (c == C_DOT || dig(c)) begin
                        put(K_TEXT, c);
                        mode = LX_NUM;
                    end else if (c == C_USCORE || alpha(c)) begin
                        put(K_TEXT, c);
                        mode = LX_IDENT;
                    end else begin
                        raise_err();
                    end
                end
            endcase
        end
    endfunction

    function automatic void close_and_begin(input logic [3:0] k, input logic [7:0] c);
        put(k, 8'h00);
        begin_tok(c);
    endfunction

    function automatic void stream_end();
        case (mode)
            LX_NUM, LX_SIGN: put(K_NUMBER, 8'h00);
            LX_IDENT, LX_I:  put(K_IDENT, 8'h00);
            LX_IN: begin
                put(K_TEXT, held);
                put(K_IDENT, 8'h00);
            end
            default: ;
        endcase
        raise_err();
    endfunction

    function automatic void consume(input logic [7:0] c);
        logic [7:0] l;
        string      tail;
        l = fold(c);
        tail = kw_rest(kw_sel);
        case (mode)
            LX_COMMENT: begin
                if (c == C_LF) begin
                    bump();
                    mode = LX_IDLE;
                end
            end
            LX_STRING: begin
                if (c == (single_q ? C_SQUOTE : C_DQUOTE)) begin
                    put(K_STRING, 8'h00);
                    mode = LX_IDLE;
                end else begin
                    put(K_TEXT, c);
                end
            end
            LX_AT: begin
                kw_pos = 0;
                if (l == C_LO_A || l == C_LO_D || l == C_LO_R) begin
                    kw_sel = (l == C_LO_A) ? 2'd0 : (l == C_LO_D) ? 2'd1 : 2'd2;
                    mode = LX_KW;
                end else begin
                    raise_err();
                end
            end
            LX_KW: begin
                if (kw_pos >= tail.len() || l != tail[kw_pos]) begin
                    raise_err();
                end else begin
                    kw_pos++;
                    if (kw_pos == tail.len())
                        mode = LX_KW_END;
                end
            end
            LX_KW_END: begin
                if (ws(c))
                    close_and_begin(K_KW_BASE + 4'(kw_sel), c);
                else
                    raise_err();
            end
            LX_I: begin
                if (l == C_LO_N) begin
                    held = c;
                    mode = LX_IN;
                end else if (idc(c)) begin
                    put(K_TEXT, c);
                    mode = LX_IDENT;
                end else begin
                    close_and_begin(K_IDENT, c);
                end
            end
            LX_IN: begin
                if (l == C_LO_F) begin
                    put(K_TEXT, C_LO_N);
                    put(K_TEXT, C_LO_F);
                    put(K_NUMBER, 8'h00);
                    mode = LX_IDLE;
                end else begin
                    put(K_TEXT, held);
                    if (idc(c)) begin
                        put(K_TEXT, c);
                        mode = LX_IDENT;
                    end else begin
                        close_and_begin(K_IDENT, c);
                    end
                end
            end
            LX_SIGN: begin
                if (l == C_LO_I) begin
                    put(K_TEXT, C_LO_I);
                    mode = LX_SIGN_I;
                end else if (numc(c)) begin
                    put(K_TEXT, c);
                    mode = LX_NUM;
                end else begin
                    close_and_begin(K_NUMBER, c);
                end
            end
            LX_SIGN_I: begin
                if (l == C_LO_N) begin
                    put(K_TEXT, C_LO_N);
                    mode = LX_SIGN_IN;
                end else begin
                    raise_err();
                end
            end
            LX_SIGN_IN: begin
                if (l == C_LO_F) begin
                    put(K_TEXT, C_LO_F);
                    put(K_NUMBER, 8'h00);
                    mode = LX_IDLE;
                end else begin
                    raise_err();
                end
            end
            LX_NUM: begin
                if (numc(c))
                    put(K_TEXT, c);
                else
                    close_and_begin(K_NUMBER, c);
            end
            LX_IDENT: begin
                if (idc(c))
                    put(K_TEXT, c);
                else
                    close_and_begin(K_IDENT, c);
            end
            default: begin_tok(c);
        endcase
    endfunction

    function automatic void lex_step(input logic [7:0] b, input logic eos);
        step_items.delete();
        if (stuck)
            put(K_ERR, 8'h00);
        else if (eos)
            stream_end();
        else
            consume(b);
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].last = 1'b1;
        foreach (step_items[i])
            due_tokens.insert(due_tokens.size(), step_items[i]);
    endfunction

    function automatic void cmp(input string fld, input int unsigned exp_v,
                                input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", fld, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = LX_IDLE;
            kw_pos = 0;
            kw_sel = 2'd0;
            single_q = 1'b0;
            held = 8'h00;
            stuck = 1'b0;
            lines = 16'd1;
            due_tokens.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                lex_step(i_req.char_byte, i_req.end_of_stream);
            if (i_res.valid && i_res.ready) begin
                if (due_tokens.size() == 0) begin
                    $error("unexpected result: item_kind %0d", i_res.item_kind);
                    fails++;
                end else begin
                    want = due_tokens.pop_front();
                    cmp("item_kind", want.kind, i_res.item_kind);
                    cmp("text_char", want.ch, i_res.text_char);
                    cmp("line_number", want.line, i_res.line_number);
                    cmp("last_of_input", want.last, i_res.last_of_input);
                end
            end
        end
        pend = due_tokens.size();
    end

endmodule

[sim/data_file_token_lexer_core_tb.sv]
module data_file_token_lexer_core_tb;
    import dftl_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE      = 20;

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   sent;
    int   quiet;
    int   fail_cnt;
    int   pending;

    string punct_set = ",{}[]()";
    string num_lead  = ".0123456789+-";
    string num_set   = "+-.0123456789eE";
    string id_lead   = "_ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    string id_set    = "_-0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    string bad_set   = "!#$&*/:;<=>?\\^|~";

    dftl_in_if  rq ();
    dftl_out_if rs ();

    data_file_token_lexer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rq),
        .o_res   (rs)
    );

    data_file_token_lexer_core_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (rq),
        .i_res      (rs),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            rs.ready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rq.valid && rq.ready) || (rs.valid && rs.ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("data_file_token_lexer_core_tb: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_req(input logic [7:0] b, input logic eos);
        while (!calm && $urandom_range(99) < 13) begin
            rq.valid <= 1'b0;
            @(negedge i_clk);
        end
        rq.valid         <= 1'b1;
        rq.char_byte     <= b;
        rq.end_of_stream <= eos;
        @(posedge i_clk);
        while (!rq.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_req(s[i], 1'b0);
    endtask

    function automatic logic [7:0] ws_byte();
        int r;
        r = $urandom_range(6);
        return (r < 5) ? 8'h09 + 8'(r) : C_SPACE;
    endfunction

    function automatic logic [7:0] sep_byte();
        return $urandom_range(1) ? ws_byte() : punct_set[$urandom_range(6)];
    endfunction

    function automatic logic [7:0] flip(input logic [7:0] c);
        return $urandom_range(1) ? c ^ 8'h20 : c;
    endfunction

    function automatic string kw_name(input int k);
        case (k)
            0: return "attribute";
            1: return "data";
            default: return "relation";
        endcase
    endfunction

    task automatic send_token();
        int         pick;
        int         n;
        logic [7:0] c;
        logic [7:0] q;
        logic [7:0] word[$];
        string      s;
        pick = $urandom_range(99);
        if (pick < 12) begin
            push_req(ws_byte(), 1'b0);
        end else if (pick < 20) begin
            push_req(C_PCT, 1'b0);
            n = $urandom_range(8);
            repeat (n) begin
                c = 8'($urandom_range(255));
                push_req((c == C_LF) ? C_SPACE : c, 1'b0);
            end
            push_req(C_LF, 1'b0);
        end else if (pick < 35) begin
            push_req(punct_set[$urandom_range(6)], 1'b0);
        end else if (pick < 50) begin
            q = $urandom_range(1) ? C_SQUOTE : C_DQUOTE;
            push_req(q, 1'b0);
            n = $urandom_range(8);
            repeat (n) begin
                c = 8'($urandom_range(255));
                push_req((c == q) ? 8'hFF : c, 1'b0);
            end
            push_req(q, 1'b0);
        end else if (pick < 58) begin
            s = kw_name($urandom_range(2));
            push_req(C_AT, 1'b0);
            for (int i = 0; i < s.len(); i++)
                push_req(flip(s[i]), 1'b0);
            push_req(ws_byte(), 1'b0);
        end else if (pick < 72) begin
            push_req(num_lead[$urandom_range(num_lead.len() - 1)], 1'b0);
            n = $urandom_range(5);
            repeat (n)
                push_req(num_set[$urandom_range(num_set.len() - 1)], 1'b0);
            push_req(sep_byte(), 1'b0);
        end else if (pick < 80) begin
            if ($urandom_range(1)) begin
                push_req(C_LO_I, 1'b0);
            end else begin
                push_req($urandom_range(1) ? C_PLUS : C_MINUS, 1'b0);
                push_req(flip(C_LO_I), 1'b0);
            end
            push_req(flip(C_LO_N), 1'b0);
            push_req(flip(C_LO_F), 1'b0);
        end else begin
            word.insert(word.size(), id_lead[$urandom_range(id_lead.len() - 1)]);
            n = $urandom_range(6);
            repeat (n)
                word.insert(word.size(), id_set[$urandom_range(id_set.len() - 1)]);
            // keep a leading "inf" from turning into a number
            if (word.size() >= 3 && word[0] == C_LO_I && (word[1] | 8'h20) == C_LO_N &&
                (word[2] | 8'h20) == C_LO_F)
                word[2] = C_USCORE;
            foreach (word[i])
                push_req(word[i], 1'b0);
            push_req(sep_byte(), 1'b0);
        end
    endtask

    task automatic send_error_tail();
        case ($urandom_range(13))
            0: begin
                if ($urandom_range(1))
                    push_req(8'($urandom_range(255, 128)), 1'b0);
                else
                    push_req(bad_set[$urandom_range(bad_set.len() - 1)], 1'b0);
            end
            1:  push_text("@q");
            2:  push_text("@dax");
            3:  push_text("@datax");
            4:  push_text("-ix");
            5:  push_text("+INx");
            6:  push_text("ab1");
            7:  push_text("1.5");
            8:  push_text("-");
            9:  push_text("i");
            10: push_text("iN");
            11: push_text("'ab");
            12: push_text("%c");
            default: push_text("@da");
        endcase
        push_req(8'($urandom_range(255)), 1'b1);
        repeat (6)
            push_req(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        rq.valid         = 1'b0;
        rq.char_byte     = 8'h00;
        rq.end_of_stream = 1'b0;
        rs.ready         = 1'b0;
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        sent             = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_text(",{}[]()inf inZ -INF\n'\"x'");
        while (sent < 390) begin
            calm = (sent >= 180 && sent < 290);
            send_token();
        end
        calm = 1'b0;

        push_text("sat,9 ");
        send_error_tail();
        rq.valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("data_file_token_lexer_core_tb: PASS");
        else
            $display("data_file_token_lexer_core_tb: FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/dftl_pkg.sv
rtl/dftl_chan_if.sv
rtl/dftl_lex.sv
rtl/dftl_obuf.sv
rtl/data_file_token_lexer_core.sv
sim/data_file_token_lexer_core_checker.sv
sim/data_file_token_lexer_core_tb.sv
